// File: hw/rtl/mfrb_pkg.sv
// types and constants shared by the multi fifo ring buffer modules
package mfrb_pkg;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_READ = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic read_done;
   } cmd_type;

   typedef struct packed {
      logic read_hit;
   } sts_type;

endpackage

// File: hw/rtl/mfrb_ctrl.sv
// sequencer for the multi fifo ring buffers: accept, execute, memory read, response strobe
module mfrb_ctrl
   import mfrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = sts.read_hit ? S_READ : S_IDLE;
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture   = (state_ff == S_IDLE) && start;
      cmd.exec      = (state_ff == S_EXEC);
      cmd.read_done = (state_ff == S_READ);
      rsp_valid_in  = (cmd.exec && !sts.read_hit) || cmd.read_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/mfrb_dp.sv
// datapath: request registers, per-fifo pointers and counters, word memory, response registers
module mfrb_dp
   import mfrb_pkg::*;
#(
   parameter int NUM_FIFOS  = 8,
   parameter int FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_fifo_index,
   input  logic [31:0] req_write_data,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_data,
   output logic [4:0]  rsp_fill_level,
   output logic [31:0] rsp_lost_count
);

   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int FSEL_W   = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
   localparam int ADDR_W   = FSEL_W + PTR_W;
   localparam int MEM_WORDS = NUM_FIFOS << PTR_W;
   localparam logic [4:0]       NUM_Q   = 5'(NUM_FIFOS);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FIFO_DEPTH);

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      next_pos = (p == PTR_MAX) ? '0 : p + PTR_W'(1);
   endfunction

   // captured request
   mode_type    mode_ff;
   logic [3:0]  index_ff;
   logic [31:0] data_ff;

   // per-fifo state
   logic [PTR_W-1:0] rp_ff   [NUM_FIFOS];
   logic [PTR_W-1:0] wp_ff   [NUM_FIFOS];
   logic [CNT_W-1:0] cnt_ff  [NUM_FIFOS];
   logic [31:0]      lost_ff [NUM_FIFOS];

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_q_ff;

   logic [1:0]  status_ff;
   logic [31:0] rdata_ff;
   logic [4:0]  fill_ff;
   logic [31:0] lostout_ff;

   logic              in_range;
   logic [FSEL_W-1:0] sel;
   logic [PTR_W-1:0]  cur_rp, cur_wp, rp_in, wp_in;
   logic [CNT_W-1:0]  cur_cnt, cnt_in;
   logic [31:0]       cur_lost, lost_in;
   logic              is_full, is_empty, mem_we;
   status_type        status_in;
   logic [CNT_W+4:0]  cnt_ext;

   always_comb begin
      in_range = ({1'b0, index_ff} < NUM_Q);
      sel      = in_range ? index_ff[FSEL_W-1:0] : '0;
      cur_rp   = rp_ff[sel];
      cur_wp   = wp_ff[sel];
      cur_cnt  = cnt_ff[sel];
      cur_lost = lost_ff[sel];
      is_full  = (cur_cnt == CNT_MAX);
      is_empty = (cur_cnt == '0);

      rp_in     = cur_rp;
      wp_in     = cur_wp;
      cnt_in    = cur_cnt;
      lost_in   = cur_lost;
      mem_we    = 1'b0;
      status_in = ST_OK;
      unique case (mode_ff)
         MODE_INIT: begin
            rp_in   = '0;
            wp_in   = '0;
            cnt_in  = '0;
            lost_in = '0;
         end
         MODE_READ: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               rp_in  = next_pos(cur_rp);
               cnt_in = cur_cnt - CNT_W'(1);
            end
         end
         MODE_WRITE: begin
            mem_we = 1'b1;
            if (is_full) begin
               lost_in   = cur_lost + 32'd1;
               status_in = ST_FULL;
            end else begin
               wp_in  = next_pos(cur_wp);
               cnt_in = cur_cnt + CNT_W'(1);
            end
         end
         MODE_NOP: begin
         end
         default: begin
         end
      endcase
      cnt_ext      = {5'd0, cnt_in};
      sts.read_hit = in_range && (mode_ff == MODE_READ) && !is_empty;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         index_ff <= req_fifo_index;
         data_ff  <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FIFOS; i++) begin
            rp_ff[i]   <= '0;
            wp_ff[i]   <= '0;
            cnt_ff[i]  <= '0;
            lost_ff[i] <= '0;
         end
      end else if (cmd.exec && in_range) begin
         rp_ff[sel]   <= rp_in;
         wp_ff[sel]   <= wp_in;
         cnt_ff[sel]  <= cnt_in;
         lost_ff[sel] <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && in_range && mem_we) begin
         mem[ADDR_W'({sel, cur_wp})] <= data_ff;
      end
      if (cmd.exec && sts.read_hit) begin
         mem_q_ff <= mem[ADDR_W'({sel, cur_rp})];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rdata_ff <= '0;
         if (in_range) begin
            status_ff  <= status_in;
            fill_ff    <= cnt_ext[4:0];
            lostout_ff <= lost_in;
         end else begin
            status_ff  <= ST_RANGE;
            fill_ff    <= '0;
            lostout_ff <= '0;
         end
      end else if (cmd.read_done) begin
         rdata_ff <= mem_q_ff;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_data  = rdata_ff;
   assign rsp_fill_level = fill_ff;
   assign rsp_lost_count = lostout_ff;

endmodule

// File: hw/rtl/multi_fifo_ring_buffers.sv
// top level of the multi fifo ring buffers block
//
// Holds NUM_FIFOS independent ring-buffer fifos of 32-bit words, each
// FIFO_DEPTH words deep, in one word memory. One item is one operation
// (init, read, write, or no operation) on the fifo named by req_fifo_index.
// An item is taken at a clock edge where start is high and busy is low.
// Each item gives exactly one response, shown on the rsp_ ports for one
// cycle with rsp_valid high; the receiver cannot stall it.
// The response is registered after the execute step or, for a read that
// pops a word, after a memory read step using the registered read port
// of the word memory. busy is high in the execute and memory read steps,
// so a new item is taken only once the last has left them; the execute
// step, a read-modify-write of the addressed fifo's pointers and counters,
// is the single shared step every item passes through.
// Synchronous reset clears all pointers, fill counts and lost counters and
// returns the sequencer to idle; memory contents are not cleared.
module multi_fifo_ring_buffers
   import mfrb_pkg::*;
#(
   parameter int NUM_FIFOS  = 8,
   parameter int FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_fifo_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_data,
   output logic [4:0]  rsp_fill_level,
   output logic [31:0] rsp_lost_count
);

   cmd_type cmd;
   sts_type sts;

   mfrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mfrb_dp #(
      .NUM_FIFOS  (NUM_FIFOS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_fifo_index (req_fifo_index),
      .req_write_data (req_write_data),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_level (rsp_fill_level),
      .rsp_lost_count (rsp_lost_count)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting an item");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RANGE) |->
         (rsp_fill_level == 5'd0 && rsp_lost_count == 32'd0 && rsp_read_data == 32'd0))
      else $error("out of range response carries nonzero fields");

   a_fail_nodata: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == 32'd0))
      else $error("read data on a failed operation");

endmodule

// File: sim/testbench.sv
// self-checking testbench for the multi fifo ring buffers block
module testbench
   import mfrb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_FIFOS   = 8;
   localparam int FIFO_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 100000;
   localparam int SETTLE      = 8;

   typedef struct {
      status_type  status;
      logic [31:0] read_data;
      logic [4:0]  fill_level;
      logic [31:0] lost_count;
   } fifo_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [3:0]  req_fifo_index;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_data;
   logic [4:0]  rsp_fill_level;
   logic [31:0] rsp_lost_count;

   // shadow copy of every fifo
   logic [31:0] shadow_words [NUM_FIFOS][FIFO_DEPTH];
   int unsigned shadow_rd_ptr [NUM_FIFOS];
   int unsigned shadow_wr_ptr [NUM_FIFOS];
   int unsigned shadow_fill [NUM_FIFOS];
   logic [31:0] shadow_lost [NUM_FIFOS];

   fifo_result_type pending_results[$];

   int          error_count;
   int          cycle_count;
   int          items_sent;
   int          results_seen;
   int          popped_reads;
   int          empty_reads;
   int          overflow_writes;
   int          range_hits;
   int          inits_done;
   bit          gaps_on;
   int unsigned focus_fifo;
   int unsigned burst_left;
   int unsigned burst_kind;

   multi_fifo_ring_buffers #(
      .NUM_FIFOS  (NUM_FIFOS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_fifo_index (req_fifo_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_level (rsp_fill_level),
      .rsp_lost_count (rsp_lost_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic fifo_result_type apply_fifo_op(mode_type op, logic [3:0] idx,
                                                     logic [31:0] data);
      fifo_result_type res;
      int unsigned     q;
      q = 32'(idx);
      res.status     = ST_OK;
      res.read_data  = '0;
      res.fill_level = '0;
      res.lost_count = '0;
      if (q >= NUM_FIFOS) begin
         res.status = ST_RANGE;
         range_hits++;
         return res;
      end
      unique case (op)
         MODE_INIT: begin
            shadow_rd_ptr[q] = 0;
            shadow_wr_ptr[q] = 0;
            shadow_fill[q]   = 0;
            shadow_lost[q]   = '0;
            inits_done++;
         end
         MODE_READ: begin
            if (shadow_fill[q] == 0) begin
               res.status = ST_EMPTY;
               empty_reads++;
            end else begin
               res.read_data    = shadow_words[q][shadow_rd_ptr[q]];
               shadow_rd_ptr[q] = (shadow_rd_ptr[q] + 1) % FIFO_DEPTH;
               shadow_fill[q]--;
               popped_reads++;
            end
         end
         MODE_WRITE: begin
            shadow_words[q][shadow_wr_ptr[q]] = data;
            if (shadow_fill[q] >= FIFO_DEPTH) begin
               shadow_lost[q] = shadow_lost[q] + 32'd1;
               res.status     = ST_FULL;
               overflow_writes++;
            end else begin
               shadow_wr_ptr[q] = (shadow_wr_ptr[q] + 1) % FIFO_DEPTH;
               shadow_fill[q]++;
            end
         end
         default: ;
      endcase
      res.fill_level = shadow_fill[q][4:0];
      res.lost_count = shadow_lost[q];
      return res;
   endfunction

   task automatic send_item(mode_type op, logic [3:0] idx, logic [31:0] data);
      while (gaps_on && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= op;
      req_fifo_index <= idx;
      req_write_data <= data;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(apply_fifo_op(op, idx, data));
      items_sent++;
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      fifo_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result, status %0d", rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data expected %h got %h", want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_fill_level !== want.fill_level) begin
               $error("fill_level expected %0d got %0d", want.fill_level, rsp_fill_level);
               error_count++;
            end
            if (rsp_lost_count !== want.lost_count) begin
               $error("lost_count expected %0d got %0d", want.lost_count, rsp_lost_count);
               error_count++;
            end
         end
      end
   end

   task automatic test_out_of_range();
      send_item(MODE_INIT, 4'd8, 32'h0);
      send_item(MODE_READ, 4'd15, 32'hffff_ffff);
      send_item(MODE_WRITE, 4'd10, 32'h1234_5678);
      send_item(MODE_NOP, 4'd13, 32'h0);
   endtask

   task automatic test_empty_and_nop();
      send_item(MODE_READ, 4'd0, 32'h0);
      send_item(MODE_NOP, 4'd7, 32'hffff_ffff);
   endtask

   task automatic test_data_extremes();
      send_item(MODE_WRITE, 4'd7, 32'h0000_0000);
      send_item(MODE_WRITE, 4'd7, 32'hffff_ffff);
      send_item(MODE_READ, 4'd7, 32'h0);
      send_item(MODE_READ, 4'd7, 32'h0);
   endtask

   // fill one fifo, overwrite past full, then init clears the lost count
   task automatic test_overflow();
      for (int i = 0; i < FIFO_DEPTH; i++)
         send_item(MODE_WRITE, 4'd2, $urandom);
      send_item(MODE_WRITE, 4'd2, 32'hdead_beef);
      send_item(MODE_WRITE, 4'd2, 32'ha5a5_5a5a);
      send_item(MODE_READ, 4'd2, 32'h0);
      send_item(MODE_INIT, 4'd2, 32'h0);
      send_item(MODE_READ, 4'd2, 32'h0);
   endtask

   task automatic random_item();
      int unsigned r;
      mode_type    op;
      logic [3:0]  idx;
      logic [31:0] data;
      if (burst_left == 0) begin
         focus_fifo = $urandom_range(NUM_FIFOS - 1);
         burst_kind = $urandom_range(2);
         burst_left = $urandom_range(24, 4);
      end
      burst_left--;
      r = $urandom_range(99);
      if (r < 8)
         idx = 4'($urandom_range(15, NUM_FIFOS));
      else if (r < 14)
         idx = 4'($urandom_range(15));
      else
         idx = 4'(focus_fifo);
      r = $urandom_range(99);
      if (r < 3)
         op = MODE_INIT;
      else if (r < 7)
         op = MODE_NOP;
      else if (burst_kind == 0)
         op = (r < 82) ? MODE_WRITE : MODE_READ;
      else if (burst_kind == 1)
         op = (r < 25) ? MODE_WRITE : MODE_READ;
      else
         op = (r < 53) ? MODE_WRITE : MODE_READ;
      r = $urandom_range(99);
      if (r < 8)
         data = 32'h0;
      else if (r < 16)
         data = 32'hffff_ffff;
      else
         data = $urandom;
      send_item(op, idx, data);
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) random_item();
   endtask

   task automatic test_pause_until_drained();
      test_random_traffic(20);
      wait_all_results();
      test_random_traffic(20);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = MODE_NOP;
      req_fifo_index = '0;
      req_write_data = '0;
      error_count    = 0;
      cycle_count    = 0;
      gaps_on        = 1'b1;
      burst_left     = 0;
      foreach (shadow_fill[q]) begin
         shadow_rd_ptr[q] = 0;
         shadow_wr_ptr[q] = 0;
         shadow_fill[q]   = 0;
         shadow_lost[q]   = '0;
      end
      foreach (shadow_words[q, p])
         shadow_words[q][p] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_out_of_range();
      test_empty_and_nop();
      test_data_extremes();
      test_overflow();
      test_random_traffic(300);
      gaps_on = 1'b0;
      test_random_traffic(250);
      gaps_on = 1'b1;
      test_pause_until_drained();
      test_random_traffic(310);

      wait_all_results();
      repeat (SETTLE) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end

      $display("%0d items, %0d results: %0d pops, %0d empty reads, %0d overflow writes,",
               items_sent, results_seen, popped_reads, empty_reads, overflow_writes);
      $display("%0d inits, %0d out of range items, %0d mismatches",
               inits_done, range_hits, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
